// ===== sv/assert_macros.svh =====
// Assertion macros used by the sspq checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/sspq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package sspq_pkg;

  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int COUNT_W   = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

// ===== sv/stable_sorted_priority_queue_unit.sv =====
// A result word is registered in the cycle after its input word is taken.
// Throughput: one operation per cycle while the result is not stalled; every cell compares
// against the new key in parallel and the whole chain shifts together.
// A stalled result holds the input side until it is taken.
// Reset (rst_n low, synchronous) empties the queue and clears the result valid.
module stable_sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_new_key,
  input  logic [31:0] in_new_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_key,
  output logic [31:0] out_payload,
  output logic [4:0]  out_entry_count,
  output logic        out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              acc;
  logic              full;
  logic              is_ins;
  logic              is_rem;
  sspq_pkg::cell_ctl_t ctl;

  sspq_pkg::entry_t  ent   [CAPACITY];
  logic              ge_v  [CAPACITY];

  logic              out_valid_r;
  sspq_pkg::status_t status_r;
  sspq_pkg::status_t status_nxt;
  sspq_pkg::entry_t  res_r;
  sspq_pkg::entry_t  res_nxt;
  logic [CW-1:0]     res_cnt_r;
  logic [CW+4:0]     res_cnt_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_r == CW'(CAPACITY));
  assign is_ins   = acc && (in_mode == sspq_pkg::MODE_INSERT) && !full;
  assign is_rem   = acc && (in_mode == sspq_pkg::MODE_REMOVE) && (cnt_r != '0);

  assign ctl.ins               = is_ins;
  assign ctl.rem               = is_rem;
  assign ctl.new_entry.key     = in_new_key;
  assign ctl.new_entry.payload = in_new_payload;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sspq_pkg::entry_t prev_e;
    sspq_pkg::entry_t next_e;
    logic             prev_g;

    if (i == 0) begin : g_head
      assign prev_e = ctl.new_entry;
      assign prev_g = 1'b1;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_g = ge_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = ent[i];
    end else begin : g_mid
      assign next_e = ent[i+1];
    end

    sspq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (CW'(i) < cnt_r),
      .prev_ge    (prev_g),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[i]),
      .ge         (ge_v[i])
    );
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = sspq_pkg::STAT_OK;
    res_nxt    = '0;
    if (is_ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (is_rem) begin
      cnt_nxt = cnt_r - CW'(1);
      res_nxt = ent[0];
    end
    if (in_mode == sspq_pkg::MODE_INSERT) begin
      if (full) begin
        status_nxt = sspq_pkg::STAT_FULL;
      end
    end else if (cnt_r == '0) begin
      status_nxt = sspq_pkg::STAT_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word holds while stalled; only a new input word reloads it.
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      res_r     <= res_nxt;
      res_cnt_r <= cnt_nxt;
    end
  end

  assign res_cnt_ext     = {5'd0, res_cnt_r};
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_key         = res_r.key;
  assign out_payload     = res_r.payload;
  assign out_entry_count = res_cnt_ext[4:0];
  assign out_is_empty    = (res_cnt_r == '0);

endmodule

// ===== sv/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module sspq_cell (
  input  logic              clk,
  input  sspq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              prev_ge,
  input  sspq_pkg::entry_t  prev_entry,
  input  sspq_pkg::entry_t  next_entry,
  output sspq_pkg::entry_t  entry,
  output logic              ge
);

  sspq_pkg::entry_t ent_r;
  sspq_pkg::entry_t ent_nxt;

  // Held entry ranks ahead of (or ties with) the arriving one.
  assign ge    = occ && (ent_r.key >= ctl.new_entry.key);
  assign entry = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.rem) begin
      ent_nxt = next_entry;
    end else if (ctl.ins && !ge) begin
      // The first cell that loses takes the new word, the rest shift down.
      ent_nxt = prev_ge ? ctl.new_entry : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== sv/sspq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
`include "assert_macros.svh"

module sspq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_key,
  input logic [31:0] out_payload,
  input logic        out_is_empty
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_key) && $stable(out_payload))
  `ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid && (out_status == sspq_pkg::STAT_EMPTY), out_is_empty && (out_key == '0) && (out_payload == '0))
  `ASSERT_IMPL(a_full_flag, clk, rst_n, out_valid && (out_status == sspq_pkg::STAT_FULL), !out_is_empty && (out_key == '0) && (out_payload == '0))

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (.*);

// ===== tb/stable_sorted_priority_queue_unit_tb.sv =====
// Self-checking testbench for the stable sorted priority queue unit.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_unit_tb;

  localparam int DEPTH = 16;

  typedef struct {
    sspq_pkg::status_t              status;
    logic [sspq_pkg::KEY_W-1:0]     key;
    logic [sspq_pkg::PAYLOAD_W-1:0] payload;
    logic [sspq_pkg::COUNT_W-1:0]   count;
    logic                           empty;
  } queue_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_mode = sspq_pkg::MODE_INSERT;
  logic [sspq_pkg::KEY_W-1:0]     in_new_key = '0;
  logic [sspq_pkg::PAYLOAD_W-1:0] in_new_payload = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_status;
  logic [sspq_pkg::KEY_W-1:0]     out_key;
  logic [sspq_pkg::PAYLOAD_W-1:0] out_payload;
  logic [sspq_pkg::COUNT_W-1:0]   out_entry_count;
  logic                           out_is_empty;

  // Shadow copy of the sorted queue, head at index 0.
  logic [sspq_pkg::KEY_W-1:0]     shadow_key [DEPTH];
  logic [sspq_pkg::PAYLOAD_W-1:0] shadow_payload [DEPTH];
  int                             shadow_count = 0;

  queue_result_t pending_results[$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  stable_sorted_priority_queue_unit #(.CAPACITY(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_new_key     (in_new_key),
    .in_new_payload (in_new_payload),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_key        (out_key),
    .out_payload    (out_payload),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic queue_result_t apply_to_shadow(logic mode,
                                                    logic [sspq_pkg::KEY_W-1:0] key,
                                                    logic [sspq_pkg::PAYLOAD_W-1:0] payload);
    queue_result_t r;
    int pos;
    r.status  = sspq_pkg::STAT_OK;
    r.key     = '0;
    r.payload = '0;
    if (mode == sspq_pkg::MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = sspq_pkg::STAT_FULL;
      end else begin
        // Land behind every entry with a greater or equal key.
        pos = 0;
        while (pos < shadow_count && shadow_key[pos] >= key) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_key[i]     = shadow_key[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_key[pos]     = key;
        shadow_payload[pos] = payload;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = sspq_pkg::STAT_EMPTY;
    end else begin
      r.key     = shadow_key[0];
      r.payload = shadow_payload[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_key[i-1]     = shadow_key[i];
        shadow_payload[i-1] = shadow_payload[i];
      end
      shadow_count--;
    end
    r.count = shadow_count[sspq_pkg::COUNT_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  // Hold the word until taken, then log what the queue should answer.
  task automatic send_word(logic mode, logic [sspq_pkg::KEY_W-1:0] key,
                           logic [sspq_pkg::PAYLOAD_W-1:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_new_key     <= key;
    in_new_payload <= payload;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(apply_to_shadow(mode, key, payload));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("out_key", 32'(want.key), 32'(out_key));
        compare_field("out_payload", want.payload, out_payload);
        compare_field("entry_count", 32'(want.count), 32'(out_entry_count));
        compare_field("is_empty", 32'(want.empty), 32'(out_is_empty));
      end
    end
  end

  task automatic test_remove_on_empty();
    send_word(sspq_pkg::MODE_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(sspq_pkg::MODE_REMOVE, '0, '0);
  endtask

  // Extreme keys and payloads, plus equal keys that must leave in arrival order.
  task automatic test_extremes_and_ties();
    send_word(sspq_pkg::MODE_INSERT, 16'h0000, 32'h0000_0000);
    send_word(sspq_pkg::MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(sspq_pkg::MODE_INSERT, 16'h8000, 32'hA5A5_0001);
    send_word(sspq_pkg::MODE_INSERT, 16'h8000, 32'h5A5A_0002);
    send_word(sspq_pkg::MODE_INSERT, 16'h8000, 32'hC3C3_0003);
    send_word(sspq_pkg::MODE_INSERT, 16'h0000, 32'h1111_0004);
    repeat (7) send_word(sspq_pkg::MODE_REMOVE, '0, '0);
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < DEPTH; i++)
      send_word(sspq_pkg::MODE_INSERT, 16'(i % 3), $urandom);
    send_word(sspq_pkg::MODE_INSERT, 16'hFFFF, 32'hDEAD_BEEF);
    send_word(sspq_pkg::MODE_REMOVE, '0, '0);
    send_word(sspq_pkg::MODE_INSERT, 16'h0001, 32'h0BAD_F00D);
    send_word(sspq_pkg::MODE_INSERT, 16'h0002, 32'hFEED_FACE);
  endtask

  // Bursts lean toward insert or remove so the fill level swings end to end.
  task automatic random_traffic(int n_words);
    int sent;
    int burst;
    int insert_pct;
    logic [sspq_pkg::KEY_W-1:0] key;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(8, 40);
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      repeat (burst) begin
        case ($urandom_range(3))
          0:       key = 16'($urandom_range(7));
          1:       key = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
          default: key = 16'($urandom);
        endcase
        send_word(($urandom_range(99) < insert_pct) ? sspq_pkg::MODE_INSERT
                                                     : sspq_pkg::MODE_REMOVE,
                  key, $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(460);
    wait_drained();
    send_idle_pct = 54; recv_stall_pct = 0;  random_traffic(460);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 54; random_traffic(460);
    wait_drained();
    send_idle_pct = 16; recv_stall_pct = 16; random_traffic(460);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_remove_on_empty();
    test_extremes_and_ties();
    test_fill_to_full();
    test_random_phases();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
